// ===== src/scbpa_pkg.sv =====
package scbpa_pkg;

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned SIZE_W = 32;
  localparam int unsigned CTR_W  = 32;

  localparam int unsigned NUM_CLASSES = 3;

  localparam int unsigned SMALL_BYTES   = 64;
  localparam int unsigned MEDIUM_BYTES  = 256;
  localparam int unsigned LARGE_BYTES   = 1024;
  localparam int unsigned SMALL_BLOCKS  = 64;
  localparam int unsigned MEDIUM_BLOCKS = 32;
  localparam int unsigned LARGE_BLOCKS  = 16;

  localparam int unsigned MAX_BLOCKS =
    (SMALL_BLOCKS > MEDIUM_BLOCKS)
      ? ((SMALL_BLOCKS > LARGE_BLOCKS) ? SMALL_BLOCKS : LARGE_BLOCKS)
      : ((MEDIUM_BLOCKS > LARGE_BLOCKS) ? MEDIUM_BLOCKS : LARGE_BLOCKS);
  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

  localparam logic [ADDR_W-1:0] CLASS_BYTES [NUM_CLASSES] = '{
    ADDR_W'(SMALL_BYTES), ADDR_W'(MEDIUM_BYTES), ADDR_W'(LARGE_BYTES)
  };
  localparam int unsigned CLASS_BLOCKS [NUM_CLASSES] = '{
    SMALL_BLOCKS, MEDIUM_BLOCKS, LARGE_BLOCKS
  };

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGE_BASE  = 2'd2;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    CLASS_SMALL  = 2'd0,
    CLASS_MEDIUM = 2'd1,
    CLASS_LARGE  = 2'd2,
    CLASS_NONE   = 2'd3
  } size_class_t;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_EXHAUSTED      = 3'd1,
    ST_OVERSIZE_ALLOC = 3'd2,
    ST_BAD_ADDRESS    = 3'd3,
    ST_NOT_IN_USE     = 3'd4,
    ST_OVERSIZE_FREE  = 3'd5
  } status_t;

  typedef struct packed {
    action_t             action;
    logic [SIZE_W-1:0]   request_size;
    logic [ADDR_W-1:0]   free_address;
  } req_word_t;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   block_address;
    size_class_t         size_class;
    logic [CTR_W-1:0]    allocations;
    logic [CTR_W-1:0]    hits;
    logic [CTR_W-1:0]    misses;
  } rsp_word_t;

  typedef struct packed {
    logic              pop;
    logic              push;
    logic [IDX_W-1:0]  idx;
  } pool_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0]      count;
    logic [IDX_W-1:0]      top;
    logic [MAX_BLOCKS-1:0] in_use;
  } pool_view_t;

endpackage

// ===== src/scbpa_pool.sv =====
module scbpa_pool import scbpa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] blocks,
  input  pool_cmd_t        cmd,
  output pool_view_t       view
);

  logic [IDX_W-1:0]      mem [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] written;
  logic [MAX_BLOCKS-1:0] in_use;
  logic [CNT_W-1:0]      count;
  logic [IDX_W-1:0]      top_reg;
  logic                  top_from_mem;
  logic [IDX_W-1:0]      rd_data;
  logic [IDX_W-1:0]      rd_addr_q;
  logic                  rd_hit;
  logic [IDX_W-1:0]      top;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      wr_addr;
  logic                  rd_en;
  logic                  wr_en;

  // top of stack lives in a register; entries below it sit in the array
  // an entry never written reads back as its own index
  assign top = top_from_mem ? (rd_hit ? rd_data : rd_addr_q) : top_reg;

  assign rd_addr = IDX_W'(count - CNT_W'(2));
  assign wr_addr = IDX_W'(count - CNT_W'(1));
  assign rd_en   = cmd.pop && (count > CNT_W'(1));
  assign wr_en   = cmd.push && (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= blocks;
      in_use       <= '0;
      written      <= '0;
      top_reg      <= IDX_W'(blocks - CNT_W'(1));
      top_from_mem <= 1'b0;
    end else if (cmd.pop) begin
      count        <= count - CNT_W'(1);
      in_use[top]  <= 1'b1;
      top_from_mem <= 1'b1;
    end else if (cmd.push) begin
      count           <= count + CNT_W'(1);
      in_use[cmd.idx] <= 1'b0;
      top_reg         <= cmd.idx;
      top_from_mem    <= 1'b0;
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= top;
    end
    if (rd_en) begin
      rd_data   <= mem[rd_addr];
      rd_addr_q <= rd_addr;
      rd_hit    <= written[rd_addr];
    end
  end

  assign view.count  = count;
  assign view.top    = top;
  assign view.in_use = in_use;

endmodule

// ===== src/size_class_block_pool_allocator.sv =====
// Size-class block pool allocator. Three pools of fixed blocks (small, medium,
// large), each with a free-index stack and an in-use bitmap. An allocate takes
// the smallest class that fits request_size, pops a free index and returns
// base + index * block size; a free turns the address into an index, checks
// range and in-use bit, and pushes the index back. Every request word gives
// exactly one response word carrying status and the running allocation, hit
// and miss counts. One request is taken per clock while the response is not
// stalled: the request sits in an input register, the pool lookup, stack
// update and address math run between it and an output register, in which the
// response lands. Stacks come out of reset full with no clearing pass; the next
// stack top is fetched by a registered read of the stack array during the pop.
// The user must write base registers on the cfg port only while no request is
// in flight; the block itself does not enforce it. cfg_ready is always high.
module size_class_block_pool_allocator import scbpa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_word_t            req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_word_t            rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  logic [ADDR_W-1:0] base [NUM_CLASSES];
  logic              req_full;
  req_word_t         req_q;
  logic              fire;
  logic [CTR_W-1:0]  allocations, allocations_next;
  logic [CTR_W-1:0]  hits, hits_next;
  logic [CTR_W-1:0]  misses, misses_next;
  rsp_word_t         rsp_next;
  size_class_t       cls;

  pool_cmd_t         cmd      [NUM_CLASSES];
  pool_view_t        views    [NUM_CLASSES];
  logic [ADDR_W-1:0] span     [NUM_CLASSES];
  logic [ADDR_W-1:0] free_blk [NUM_CLASSES];
  logic [IDX_W-1:0]  free_idx [NUM_CLASSES];
  logic [ADDR_W-1:0] grant    [NUM_CLASSES];
  logic              in_range [NUM_CLASSES];
  logic              busy     [NUM_CLASSES];
  logic              full     [NUM_CLASSES];

  assign fire      = req_full && (!rsp_valid || !rsp_stall);
  assign req_stall = req_full && !fire;
  assign cfg_ready = 1'b1;

  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_class
    assign span[c]     = req_q.free_address - base[c];
    assign free_blk[c] = span[c] / CLASS_BYTES[c];
    assign in_range[c] = free_blk[c] < ADDR_W'(CLASS_BLOCKS[c]);
    assign free_idx[c] = free_blk[c][IDX_W-1:0];
    assign busy[c]     = views[c].in_use[free_idx[c]];
    assign full[c]     = views[c].count >= CNT_W'(CLASS_BLOCKS[c]);
    assign grant[c]    = base[c] + ADDR_W'(views[c].top) * CLASS_BYTES[c];

    scbpa_pool u_pool (
      .clk    (clk),
      .rst    (rst),
      .blocks (CNT_W'(CLASS_BLOCKS[c])),
      .cmd    (cmd[c]),
      .view   (views[c])
    );
  end

  always_comb begin
    if (req_q.request_size <= SIZE_W'(SMALL_BYTES)) begin
      cls = CLASS_SMALL;
    end else if (req_q.request_size <= SIZE_W'(MEDIUM_BYTES)) begin
      cls = CLASS_MEDIUM;
    end else if (req_q.request_size <= SIZE_W'(LARGE_BYTES)) begin
      cls = CLASS_LARGE;
    end else begin
      cls = CLASS_NONE;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      cmd[c] = '0;
    end
    allocations_next       = allocations;
    hits_next              = hits;
    misses_next            = misses;
    rsp_next.status        = ST_OK;
    rsp_next.block_address = '0;
    rsp_next.size_class    = cls;

    if (req_q.action == ACT_ALLOC) begin
      allocations_next = allocations + CTR_W'(1);
      if (cls == CLASS_NONE) begin
        misses_next     = misses + CTR_W'(1);
        rsp_next.status = ST_OVERSIZE_ALLOC;
      end else if (views[cls].count == '0) begin
        misses_next     = misses + CTR_W'(1);
        rsp_next.status = ST_EXHAUSTED;
      end else begin
        hits_next              = hits + CTR_W'(1);
        rsp_next.block_address = grant[cls];
        cmd[cls].pop           = fire;
      end
    end else begin
      if (cls == CLASS_NONE) begin
        rsp_next.status = ST_OVERSIZE_FREE;
      end else if (!in_range[cls]) begin
        rsp_next.status = ST_BAD_ADDRESS;
      end else if (!busy[cls] || full[cls]) begin
        rsp_next.status = ST_NOT_IN_USE;
      end else begin
        cmd[cls].push = fire;
        cmd[cls].idx  = free_idx[cls];
      end
    end

    rsp_next.allocations = allocations_next;
    rsp_next.hits        = hits_next;
    rsp_next.misses      = misses_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full    <= 1'b0;
      rsp_valid   <= 1'b0;
      allocations <= '0;
      hits        <= '0;
      misses      <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        base[c] <= '0;
      end
    end else begin
      if (!req_stall) begin
        req_full <= req_valid;
      end
      if (fire) begin
        rsp_valid   <= 1'b1;
        allocations <= allocations_next;
        hits        <= hits_next;
        misses      <= misses_next;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SMALL_BASE:  base[CLASS_SMALL]  <= cfg_data;
          CFG_MEDIUM_BASE: base[CLASS_MEDIUM] <= cfg_data;
          CFG_LARGE_BASE:  base[CLASS_LARGE]  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_q <= req;
    end
    if (fire) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== src/scbpa_checker.sv =====
module scbpa_checker import scbpa_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_stall,
  input req_word_t            req,
  input logic                 rsp_valid,
  input logic                 rsp_stall,
  input rsp_word_t            rsp,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [ADDR_W-1:0]    cfg_data
);

  // a stalled response word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response word changed while stalled");

  // every allocate is either a hit or a miss
  a_ctr_sum: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.allocations == CTR_W'(rsp.hits + rsp.misses))
    else $error("allocation count differs from hits plus misses");

  // oversize status goes with no size class and only then
  a_oversize: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((rsp.size_class == CLASS_NONE) ==
                   (rsp.status == ST_OVERSIZE_ALLOC || rsp.status == ST_OVERSIZE_FREE)))
    else $error("size class and oversize status disagree");

  // no address comes with a failed request
  a_fail_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.block_address == '0)
    else $error("failed request returned an address");

  // the allocation count does not move on a response to a failed free
  a_alloc_step: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_stall ##1 rsp_valid && $changed(rsp) &&
      (rsp.status == ST_OVERSIZE_FREE || rsp.status == ST_BAD_ADDRESS ||
       rsp.status == ST_NOT_IN_USE)
      |-> rsp.allocations == $past(rsp.allocations))
    else $error("free changed the allocation count");

endmodule

bind size_class_block_pool_allocator scbpa_checker u_checker (.*);

// ===== verif/pool_grant_checker.sv =====
module pool_grant_checker import scbpa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_stall,
  input  req_word_t            req,
  input  logic                 rsp_valid,
  input  logic                 rsp_stall,
  input  rsp_word_t            rsp,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  output int unsigned          errors,
  output int unsigned          awaited
);

  logic [ADDR_W-1:0]     base_of [NUM_CLASSES];
  logic [IDX_W-1:0]      free_ids [NUM_CLASSES][MAX_BLOCKS];
  int unsigned           free_left [NUM_CLASSES];
  logic [MAX_BLOCKS-1:0] taken [NUM_CLASSES];
  logic [CTR_W-1:0]      alloc_total;
  logic [CTR_W-1:0]      hit_total;
  logic [CTR_W-1:0]      miss_total;
  rsp_word_t             awaited_replies [$];
  int unsigned           faults = 0;

  task automatic clear_pools();
    for (int k = 0; k < NUM_CLASSES; k++) begin
      base_of[k] = '0;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        free_ids[k][i] = IDX_W'(i);
      end
      free_left[k] = CLASS_BLOCKS[k];
      taken[k] = '0;
    end
    alloc_total = '0;
    hit_total = '0;
    miss_total = '0;
    awaited_replies.delete();
  endtask

  function automatic size_class_t class_for(logic [SIZE_W-1:0] size);
    if (size <= SMALL_BYTES) return CLASS_SMALL;
    if (size <= MEDIUM_BYTES) return CLASS_MEDIUM;
    if (size <= LARGE_BYTES) return CLASS_LARGE;
    return CLASS_NONE;
  endfunction

  function automatic rsp_word_t serve_request(req_word_t w);
    rsp_word_t         r;
    size_class_t       c;
    int unsigned       k;
    int unsigned       blocks;
    int unsigned       idx;
    logic [ADDR_W-1:0] span;
    logic [ADDR_W-1:0] slot;
    r = '0;
    c = class_for(w.request_size);
    k = int'(c);
    blocks = 0;
    if (c != CLASS_NONE) blocks = CLASS_BLOCKS[k];
    r.size_class = c;
    r.status = ST_OK;
    if (w.action == ACT_ALLOC) begin
      alloc_total++;
      if (c == CLASS_NONE) begin
        miss_total++;
        r.status = ST_OVERSIZE_ALLOC;
      end else if (free_left[k] == 0 || free_left[k] > blocks) begin
        miss_total++;
        r.status = ST_EXHAUSTED;
      end else begin
        free_left[k]--;
        idx = int'(free_ids[k][free_left[k]]) % blocks;
        taken[k][idx] = 1'b1;
        r.block_address = base_of[k] + ADDR_W'(idx) * CLASS_BYTES[k];
        hit_total++;
      end
    end else if (c == CLASS_NONE) begin
      r.status = ST_OVERSIZE_FREE;
    end else begin
      span = w.free_address - base_of[k];
      slot = span / CLASS_BYTES[k];
      if (slot >= ADDR_W'(blocks)) begin
        r.status = ST_BAD_ADDRESS;
      end else begin
        idx = int'(slot);
        if (!taken[k][idx] || free_left[k] >= blocks) begin
          r.status = ST_NOT_IN_USE;
        end else begin
          taken[k][idx] = 1'b0;
          free_ids[k][free_left[k]] = IDX_W'(idx);
          free_left[k]++;
        end
      end
    end
    r.allocations = alloc_total;
    r.hits = hit_total;
    r.misses = miss_total;
    return r;
  endfunction

  task automatic flag(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      faults++;
    end
  endtask

  always @(posedge clk) begin : track
    rsp_word_t want;
    if (rst) begin
      clear_pools();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SMALL_BASE:  base_of[CLASS_SMALL] = cfg_data;
          CFG_MEDIUM_BASE: base_of[CLASS_MEDIUM] = cfg_data;
          CFG_LARGE_BASE:  base_of[CLASS_LARGE] = cfg_data;
          default: ;
        endcase
      end
      if (req_valid && !req_stall) begin
        awaited_replies.insert(awaited_replies.size(), serve_request(req));
      end
      if (rsp_valid && !rsp_stall) begin
        if (awaited_replies.size() == 0) begin
          $error("response word with no request outstanding");
          faults++;
        end else begin
          want = awaited_replies.pop_front();
          flag("status", 64'(want.status), 64'(rsp.status));
          flag("block_address", 64'(want.block_address), 64'(rsp.block_address));
          flag("size_class", 64'(want.size_class), 64'(rsp.size_class));
          flag("allocations", 64'(want.allocations), 64'(rsp.allocations));
          flag("hits", 64'(want.hits), 64'(rsp.hits));
          flag("misses", 64'(want.misses), 64'(rsp.misses));
        end
      end
    end
    errors = faults;
    awaited = awaited_replies.size();
  end

endmodule

// ===== verif/size_class_block_pool_allocator_test.sv =====
module size_class_block_pool_allocator_test import scbpa_pkg::*;;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 350;
  localparam int unsigned SETTINGS_N  = 4;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_word_t            req = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_word_t            rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SMALL_BASE;
  logic [ADDR_W-1:0]    cfg_data = '0;

  int unsigned          errors;
  int unsigned          awaited;
  bit                   calm = 1'b0;
  int unsigned          quiet = 0;
  int unsigned          sent_total = 0;
  int unsigned          grants = 0;
  logic [ADDR_W-1:0]    cur_base [NUM_CLASSES] = '{default: '0};
  logic [IDX_W-1:0]     live_ids [NUM_CLASSES][$];
  logic [IDX_W-1:0]     last_freed [NUM_CLASSES] = '{default: '0};
  action_t              kinds_sent [$];

  size_class_block_pool_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pool_grant_checker grant_check (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .awaited   (awaited)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    rsp_stall <= !calm && ($urandom_range(99) < 10);
  end

  // remember granted block indexes so frees can target live blocks
  always @(posedge clk) begin : note_grants
    action_t     kind;
    int unsigned c;
    if (rst) begin
      kinds_sent.delete();
      for (int k = 0; k < NUM_CLASSES; k++) live_ids[k].delete();
    end else begin
      if (req_valid && !req_stall) kinds_sent.insert(kinds_sent.size(), req.action);
      if (rsp_valid && !rsp_stall && kinds_sent.size() != 0) begin
        kind = kinds_sent.pop_front();
        c = int'(rsp.size_class);
        if (kind == ACT_ALLOC && rsp.status == ST_OK && rsp.size_class != CLASS_NONE) begin
          live_ids[c].insert(live_ids[c].size(),
            IDX_W'((rsp.block_address - cur_base[c]) / CLASS_BYTES[c]));
          grants++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] any_address();
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [SIZE_W-1:0] size_for(int unsigned c);
    case (c)
      CLASS_SMALL:  return $urandom_range(SMALL_BYTES);
      CLASS_MEDIUM: return $urandom_range(MEDIUM_BYTES, SMALL_BYTES + 1);
      CLASS_LARGE:  return $urandom_range(LARGE_BYTES, MEDIUM_BYTES + 1);
      default:      return $urandom_range(1) ? SIZE_W'(LARGE_BYTES + 1)
                                             : $urandom_range(32'hFFFF_FFFF, LARGE_BYTES + 1);
    endcase
  endfunction

  // address inside a block, sometimes off its first byte
  function automatic logic [ADDR_W-1:0] block_at(int unsigned c, logic [IDX_W-1:0] id);
    logic [ADDR_W-1:0] offset;
    offset = $urandom_range(1) ? '0 : ADDR_W'($urandom_range(32'(CLASS_BYTES[c]) - 1));
    return cur_base[c] + ADDR_W'(id) * CLASS_BYTES[c] + offset;
  endfunction

  task automatic send(req_word_t w);
    if (!calm && $urandom_range(99) < 4) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sent_total++;
  endtask

  task automatic ask(action_t a, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
    req_word_t w;
    w.action = a;
    w.request_size = size;
    w.free_address = addr;
    send(w);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    do @(negedge clk); while (awaited != 0);
    @(posedge clk);
  endtask

  task automatic program_bases(logic [ADDR_W-1:0] s, logic [ADDR_W-1:0] m,
                               logic [ADDR_W-1:0] l);
    logic [CFG_IDX_W-1:0] regs [NUM_CLASSES];
    regs = '{CFG_SMALL_BASE, CFG_MEDIUM_BASE, CFG_LARGE_BASE};
    cur_base = '{s, m, l};
    cfg_valid <= 1'b1;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      cfg_index <= regs[k];
      cfg_data <= cur_base[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_request(bit filling);
    req_word_t   w;
    int unsigned c;
    int unsigned pick;
    int unsigned j;
    c = $urandom_range(2);
    w.action = ACT_ALLOC;
    w.request_size = size_for(c);
    w.free_address = any_address();
    if ($urandom_range(99) < (filling ? 75 : 25)) begin
      if ($urandom_range(19) == 0) w.request_size = size_for(CLASS_NONE);
    end else begin
      w.action = ACT_FREE;
      pick = $urandom_range(99);
      if (pick < 75 && live_ids[c].size() != 0) begin
        j = $urandom_range(live_ids[c].size() - 1);
        last_freed[c] = live_ids[c][j];
        live_ids[c].delete(j);
        w.free_address = block_at(c, last_freed[c]);
      end else if (pick < 82) begin
        w.free_address = block_at(c, last_freed[c]);
      end else if (pick < 90) begin
        w.free_address = $urandom_range(1)
          ? cur_base[c] - ADDR_W'($urandom_range(4096, 1))
          : cur_base[c] + ADDR_W'(CLASS_BLOCKS[c]) * CLASS_BYTES[c] +
            ADDR_W'($urandom_range(4095));
      end else if (pick < 95) begin
        w.request_size = size_for(CLASS_NONE);
      end else begin
        w.request_size = $urandom();
      end
    end
    send(w);
  endtask

  initial begin
    bit filling;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset bases are all zero, stacks pop their highest index first
    ask(ACT_ALLOC, '0, '1);
    ask(ACT_ALLOC, SMALL_BYTES, '0);
    ask(ACT_ALLOC, SMALL_BYTES + 1, '0);
    ask(ACT_ALLOC, MEDIUM_BYTES, '0);
    ask(ACT_ALLOC, MEDIUM_BYTES + 1, '0);
    ask(ACT_ALLOC, LARGE_BYTES, '0);
    ask(ACT_ALLOC, LARGE_BYTES + 1, '0);
    ask(ACT_ALLOC, '1, '0);
    ask(ACT_FREE, '0, ADDR_W'(63 * SMALL_BYTES + 5));
    ask(ACT_FREE, 1, ADDR_W'(63 * SMALL_BYTES));
    ask(ACT_FREE, 7, '0);
    ask(ACT_FREE, SMALL_BYTES, ADDR_W'(SMALL_BLOCKS * SMALL_BYTES));
    ask(ACT_FREE, SMALL_BYTES, '1);
    ask(ACT_FREE, MEDIUM_BYTES, ADDR_W'(32 * MEDIUM_BYTES - 1));
    ask(ACT_FREE, LARGE_BYTES, ADDR_W'(15 * LARGE_BYTES));
    ask(ACT_FREE, LARGE_BYTES + 1, '0);
    ask(ACT_FREE, '1, '1);
    ask(ACT_ALLOC, 1, '0);

    for (int s = 0; s < SETTINGS_N; s++) begin
      settle();
      case (s)
        0: program_bases(48'h0000_0000_1000, 48'h0000_0010_0000, 48'h0000_4000_0000);
        1: program_bases(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_F000, 48'hFFFF_FFFF_C000);
        2: program_bases(any_address(), any_address(), any_address());
        default: program_bases('0, '0, '0);
      endcase
      calm = (s == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) filling = (n == 0) || $urandom_range(1);
        random_request(filling);
      end
    end
    settle();
    repeat (4) @(posedge clk);

    $display("sent %0d requests over %0d base settings plus the reset bases",
             sent_total, SETTINGS_N);
    $display("%0d blocks were granted from the pools", grants);
    if (errors == 0 && awaited == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/scbpa_pkg.sv
src/scbpa_pool.sv
src/size_class_block_pool_allocator.sv
src/scbpa_checker.sv
verif/pool_grant_checker.sv
verif/size_class_block_pool_allocator_test.sv
